FILE: rtl/gram_schmidt_orthonormalizer_top_assert.svh
// Assertion macros shared by the checker of the orthonormalizer.
`ifndef GRAM_SCHMIDT_ORTHONORMALIZER_TOP_ASSERT_SVH
`define GRAM_SCHMIDT_ORTHONORMALIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSO_AP_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("orthonormalizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define GSO_AP_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("orthonormalizer check failed");

`endif

FILE: rtl/gso_pkg.sv
`default_nettype none
package gso_pkg;

    localparam int MAX_VECTORS    = 8;
    localparam int MAX_COMPONENTS = 8;

    localparam int DATA_W = 16;
    localparam int CFG_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTORS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS = 2'd1;

    localparam int CI_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int VI_W = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int K_W  = $clog2(MAX_COMPONENTS + 1);
    localparam int V_W  = $clog2(MAX_VECTORS + 1);
    localparam int BA_W = (MAX_VECTORS * MAX_COMPONENTS > 1) ?
                          $clog2(MAX_VECTORS * MAX_COMPONENTS) : 1;

    // Dot product, remainder and norm widths.
    localparam int C_W      = 2 * DATA_W + $clog2(MAX_COMPONENTS);
    localparam int R_W      = C_W + DATA_W + $clog2(MAX_VECTORS) + 1;
    localparam int X_SHIFT  = 30;
    localparam int MAG_W    = 28;
    localparam int SHIFT_W  = $clog2(R_W);
    localparam int SQ_W     = 2 * MAG_W + $clog2(MAX_COMPONENTS);
    localparam int NRM_W    = (SQ_W + 1) / 2;
    localparam int OUT_FRAC = 15;
    localparam int Q_W      = OUT_FRAC + 1;
    localparam int DIV_W    = MAG_W + OUT_FRAC + 1;
    localparam int DV_W     = NRM_W + Q_W - 1;

    localparam logic [DATA_W-1:0] POS_MAX = 16'h7FFF;

    typedef struct packed {
        logic                     write;
        logic [CI_W-1:0]          index;
        logic signed [DATA_W-1:0] value;
        logic                     finish;
        logic [VI_W-1:0]          vector;
        logic [K_W-1:0]           count;
        logic                     last_set;
    } gso_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
        logic              last_of_vector;
        logic              last_of_set;
        logic              degenerate;
    } gso_result_t;

    function automatic int eff_count(input logic [CFG_W-1:0] value, input int limit);
        if (value == '0)
        begin
            return 1;
        end
        if (int'(value) > limit)
        begin
            return limit;
        end
        return int'(value);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gso_sqrt.sv
`default_nettype none
module gso_sqrt
    import gso_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SQ_W-1:0]  radicand,
    output logic                  done,
    output logic [NRM_W-1:0]      root
);

    localparam int CNT_W = $clog2(NRM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]  num_reg, num_next;
    logic [SQ_W-1:0]  res_reg, res_next;
    logic [SQ_W-1:0]  bit_reg, bit_next;
    logic [NRM_W-1:0] root_reg, root_next;
    logic [SQ_W:0]    trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    // One result bit per cycle, digit by digit.
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            num_next = radicand;
            res_next = '0;
            bit_next = SQ_W'(1) << (2 * (NRM_W - 1));
        end
        else if (run_reg)
        begin
            if ({1'b0, num_reg} >= trial)
            begin
                num_next = num_reg - trial[SQ_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NRM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
                root_next = res_next[NRM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

FILE: rtl/gso_div.sv
`default_nettype none
module gso_div
    import gso_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [NRM_W-1:0]  divisor,
    output logic                   done,
    output logic [Q_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DV_W-1:0]  dv_reg, dv_next;
    logic [Q_W-1:0]   q_reg, q_next;

    // Restoring division, one quotient bit per cycle. The quotient is known
    // to stay below 2^Q_W, so only Q_W steps are needed.
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        q_next    = q_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = dividend;
            dv_next  = DV_W'(divisor) << (Q_W - 1);
            q_next   = '0;
        end
        else if (run_reg)
        begin
            if (DV_W'(rem_reg) >= dv_reg)
            begin
                rem_next = rem_reg - DIV_W'(dv_reg);
                q_next   = {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[Q_W-2:0], 1'b0};
            end
            dv_next  = dv_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

FILE: rtl/gso_core.sv
`default_nettype none
module gso_core
    import gso_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire gso_cmd_t    cmd,
    output logic             busy,
    output gso_result_t      result
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
    localparam logic [ST_W-1:0] ST_INIT_RD  = 5'd1;
    localparam logic [ST_W-1:0] ST_INIT_WR  = 5'd2;
    localparam logic [ST_W-1:0] ST_DOT_RD   = 5'd3;
    localparam logic [ST_W-1:0] ST_DOT_AC   = 5'd4;
    localparam logic [ST_W-1:0] ST_UPD_RD   = 5'd5;
    localparam logic [ST_W-1:0] ST_UPD_MUL  = 5'd6;
    localparam logic [ST_W-1:0] ST_UPD_WR   = 5'd7;
    localparam logic [ST_W-1:0] ST_MAX_RD   = 5'd8;
    localparam logic [ST_W-1:0] ST_MAX_AC   = 5'd9;
    localparam logic [ST_W-1:0] ST_SHF      = 5'd10;
    localparam logic [ST_W-1:0] ST_SQ_RD    = 5'd11;
    localparam logic [ST_W-1:0] ST_SQ_MAG   = 5'd12;
    localparam logic [ST_W-1:0] ST_SQ_AC    = 5'd13;
    localparam logic [ST_W-1:0] ST_SQRT     = 5'd14;
    localparam logic [ST_W-1:0] ST_OUT_RD   = 5'd15;
    localparam logic [ST_W-1:0] ST_OUT_MAG  = 5'd16;
    localparam logic [ST_W-1:0] ST_OUT_DIV  = 5'd17;
    localparam logic [ST_W-1:0] ST_OUT_EMIT = 5'd18;

    // Input vector, basis vectors and working remainders.
    logic signed [DATA_W-1:0] xbuf_mem [MAX_COMPONENTS];
    logic signed [DATA_W-1:0] bmem_mem [MAX_VECTORS * MAX_COMPONENTS];
    logic signed [R_W-1:0]    rmem_mem [MAX_COMPONENTS];

    logic signed [DATA_W-1:0] x_rd_reg;
    logic signed [DATA_W-1:0] b_rd_reg;
    logic signed [R_W-1:0]    r_rd_reg;

    logic [ST_W-1:0]        state_reg, state_next;
    logic [CI_W-1:0]        k_reg, k_next;
    logic [VI_W-1:0]        j_reg, j_next;
    logic [K_W-1:0]         n_reg, n_next;
    logic [VI_W-1:0]        vi_reg, vi_next;
    logic                   last_set_reg, last_set_next;
    logic signed [C_W-1:0]  c_reg, c_next;
    logic signed [R_W-1:0]  prod_reg, prod_next;
    logic [R_W-1:0]         maxmag_reg, maxmag_next;
    logic [SHIFT_W-1:0]     shift_reg, shift_next;
    logic [SQ_W-1:0]        sumsq_reg, sumsq_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [NRM_W-1:0]       nrm_reg, nrm_next;
    logic [Q_W-1:0]         q_reg, q_next;
    gso_result_t            res_reg, res_next;

    logic                      x_we, b_we, r_we;
    logic [CI_W-1:0]           x_wa;
    logic [BA_W-1:0]           b_ra, b_wa;
    logic [DATA_W-1:0]         b_wd;
    logic signed [R_W-1:0]     r_wd;

    logic                      last_k;
    logic                      degen;
    logic signed [2*DATA_W-1:0] dot_prod;
    logic signed [C_W+DATA_W-1:0] upd_prod;
    logic signed [R_W-1:0]     x_ext;
    logic [R_W-1:0]            r_abs;
    logic [R_W-1:0]            r_shifted;
    logic [MAG_W-1:0]          mag_now;
    logic [2*MAG_W-1:0]        mag_sq;
    logic [DATA_W-1:0]         emit_val;

    logic                      sqrt_start, sqrt_done;
    logic [NRM_W-1:0]          sqrt_root;
    logic                      div_start, div_done;
    logic [DIV_W-1:0]          div_dividend;
    logic [Q_W-1:0]            div_q;

    assign last_k    = (k_reg == CI_W'(n_reg - 1'b1));
    assign degen     = (nrm_reg == '0);
    assign dot_prod  = x_rd_reg * b_rd_reg;
    assign upd_prod  = c_reg * b_rd_reg;
    assign x_ext     = R_W'(x_rd_reg);
    assign r_abs     = r_rd_reg[R_W-1] ? (~r_rd_reg + 1'b1) : r_rd_reg;
    assign r_shifted = r_abs >> shift_reg;
    assign mag_now   = r_shifted[MAG_W-1:0];
    assign mag_sq    = mag_reg * mag_reg;
    assign div_dividend = DIV_W'({mag_now, {OUT_FRAC{1'b0}}}) + DIV_W'(nrm_reg >> 1);

    assign x_wa = cmd.index;
    assign b_ra = BA_W'(int'(j_reg) * MAX_COMPONENTS + int'(k_reg));
    assign b_wa = BA_W'(int'(vi_reg) * MAX_COMPONENTS + int'(k_reg));

    // Round half away from zero is folded into the dividend; here the sign is
    // restored, the positive full-scale value saturates and a degenerate vector gives zero.
    always_comb
    begin
        if (degen)
        begin
            emit_val = '0;
        end
        else if (neg_reg)
        begin
            emit_val = DATA_W'(~q_reg + 1'b1);
        end
        else if (q_reg[Q_W-1])
        begin
            emit_val = POS_MAX;
        end
        else
        begin
            emit_val = DATA_W'(q_reg);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        vi_next       = vi_reg;
        last_set_next = last_set_reg;
        c_next        = c_reg;
        prod_next     = prod_reg;
        maxmag_next   = maxmag_reg;
        shift_next    = shift_reg;
        sumsq_next    = sumsq_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        nrm_next      = nrm_reg;
        q_next        = q_reg;
        res_next      = res_reg;
        res_next.valid = 1'b0;
        x_we       = 1'b0;
        b_we       = 1'b0;
        r_we       = 1'b0;
        b_wd       = emit_val;
        r_wd       = x_ext <<< X_SHIFT;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.write)
                begin
                    x_we = 1'b1;
                    if (cmd.finish)
                    begin
                        n_next        = cmd.count;
                        vi_next       = cmd.vector;
                        last_set_next = cmd.last_set;
                        k_next        = '0;
                        j_next        = '0;
                        maxmag_next   = '0;
                        shift_next    = '0;
                        sumsq_next    = '0;
                        state_next    = ST_INIT_RD;
                    end
                end
            end
            ST_INIT_RD:
            begin
                state_next = ST_INIT_WR;
            end
            ST_INIT_WR:
            begin
                r_we = 1'b1;
                if (last_k)
                begin
                    k_next     = '0;
                    c_next     = '0;
                    state_next = (vi_reg == '0) ? ST_MAX_RD : ST_DOT_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_INIT_RD;
                end
            end
            ST_DOT_RD:
            begin
                state_next = ST_DOT_AC;
            end
            ST_DOT_AC:
            begin
                c_next = c_reg + C_W'(dot_prod);
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = ST_UPD_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_DOT_RD;
                end
            end
            ST_UPD_RD:
            begin
                state_next = ST_UPD_MUL;
            end
            ST_UPD_MUL:
            begin
                prod_next  = R_W'(upd_prod);
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                r_we = 1'b1;
                r_wd = r_rd_reg - prod_reg;
                if (last_k)
                begin
                    k_next = '0;
                    c_next = '0;
                    if (j_reg == vi_reg - 1'b1)
                    begin
                        state_next = ST_MAX_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_DOT_RD;
                    end
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_UPD_RD;
                end
            end
            ST_MAX_RD:
            begin
                state_next = ST_MAX_AC;
            end
            ST_MAX_AC:
            begin
                if (r_abs > maxmag_reg)
                begin
                    maxmag_next = r_abs;
                end
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = ST_SHF;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_MAX_RD;
                end
            end
            ST_SHF:
            begin
                // Walk the largest magnitude down one bit a cycle until it fits.
                if (|maxmag_reg[R_W-1:MAG_W])
                begin
                    maxmag_next = maxmag_reg >> 1;
                    shift_next  = shift_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_SQ_RD;
                end
            end
            ST_SQ_RD:
            begin
                state_next = ST_SQ_MAG;
            end
            ST_SQ_MAG:
            begin
                mag_next   = mag_now;
                state_next = ST_SQ_AC;
            end
            ST_SQ_AC:
            begin
                sumsq_next = sumsq_reg + SQ_W'(mag_sq);
                if (last_k)
                begin
                    k_next     = '0;
                    sqrt_start = 1'b1;
                    state_next = ST_SQRT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_SQ_RD;
                end
            end
            ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    nrm_next   = sqrt_root;
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_MAG;
            end
            ST_OUT_MAG:
            begin
                mag_next = mag_now;
                neg_next = r_rd_reg[R_W-1];
                if (degen)
                begin
                    q_next     = '0;
                    state_next = ST_OUT_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_OUT_DIV;
                end
            end
            ST_OUT_DIV:
            begin
                if (div_done)
                begin
                    q_next     = div_q;
                    state_next = ST_OUT_EMIT;
                end
            end
            ST_OUT_EMIT:
            begin
                b_we = 1'b1;
                res_next.valid          = 1'b1;
                res_next.value          = emit_val;
                res_next.last_of_vector = last_k;
                res_next.last_of_set    = last_set_reg;
                res_next.degenerate     = degen;
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            xbuf_mem[x_wa] <= cmd.value;
        end
        x_rd_reg <= xbuf_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bmem_mem[b_wa] <= b_wd;
        end
        b_rd_reg <= bmem_mem[b_ra];
    end

    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            rmem_mem[k_reg] <= r_wd;
        end
        r_rd_reg <= rmem_mem[k_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            j_reg     <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        vi_reg       <= vi_next;
        last_set_reg <= last_set_next;
        c_reg        <= c_next;
        prod_reg     <= prod_next;
        maxmag_reg   <= maxmag_next;
        shift_reg    <= shift_next;
        sumsq_reg    <= sumsq_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        nrm_reg      <= nrm_next;
        q_reg        <= q_next;
    end

    gso_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sumsq_next),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    gso_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (nrm_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign result = res_reg;

endmodule
`default_nettype wire

FILE: rtl/gram_schmidt_orthonormalizer_top.sv
// Classical Gram-Schmidt orthonormalizer. Components of Q8.8 input vectors are
// written one word per start pulse, accepted when start is high and busy is
// low. A non-final component is taken and busy stays low. On the final
// component of a vector busy rises and the block projects the vector against
// the stored basis, normalizes it and emits its Q1.15 components, one word
// per result_valid pulse, each present for exactly one cycle; the receiver
// cannot stall, so it must take every word as it appears. The normalizing
// shift runs from 0 to 27. Every step runs through one read port of the
// remainder, input and basis memories, and the norm and divisions come from
// a bit-serial square root and a bit-serial divider. The user must write
// configuration only while busy is low and no vector is partly entered; the
// block itself does not enforce this.
`default_nettype none
module gram_schmidt_orthonormalizer_top
    import gso_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [DATA_W-1:0] component_value,
    output logic                          result_valid,
    output logic signed [DATA_W-1:0]      basis_value,
    output logic                          last_of_vector,
    output logic                          last_of_set,
    output logic                          degenerate,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data
);

    logic [CFG_W-1:0] vectors_reg, vectors_next;
    logic [CFG_W-1:0] components_reg, components_next;
    logic [CI_W-1:0]  ci_reg, ci_next;
    logic [VI_W-1:0]  vi_reg, vi_next;

    logic [K_W-1:0]   n_eff;
    logic [V_W-1:0]   m_eff;
    logic             accept;
    logic             finish;
    logic             last_set;
    logic             core_busy;
    gso_cmd_t         cmd;
    gso_result_t      result;

    assign n_eff    = K_W'(eff_count(components_reg, MAX_COMPONENTS));
    assign m_eff    = V_W'(eff_count(vectors_reg, MAX_VECTORS));
    assign accept   = start && !core_busy;
    assign finish   = (int'(ci_reg) + 1 >= int'(n_eff));
    assign last_set = (int'(vi_reg) + 1 >= int'(m_eff));

    always_comb
    begin
        vectors_next    = vectors_reg;
        components_next = components_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_VECTORS)
            begin
                vectors_next = cfg_data;
            end
            else if (cfg_index == CFG_COMPONENTS)
            begin
                components_next = cfg_data;
            end
        end
    end

    // Component and vector position within the set.
    always_comb
    begin
        ci_next = ci_reg;
        vi_next = vi_reg;
        if (accept)
        begin
            if (finish)
            begin
                ci_next = '0;
                vi_next = last_set ? '0 : vi_reg + 1'b1;
            end
            else
            begin
                ci_next = ci_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vectors_reg    <= CFG_W'(MAX_VECTORS);
            components_reg <= CFG_W'(MAX_COMPONENTS);
            ci_reg         <= '0;
            vi_reg         <= '0;
        end
        else
        begin
            vectors_reg    <= vectors_next;
            components_reg <= components_next;
            ci_reg         <= ci_next;
            vi_reg         <= vi_next;
        end
    end

    always_comb
    begin
        cmd.write    = accept;
        cmd.index    = ci_reg;
        cmd.value    = component_value;
        cmd.finish   = finish;
        cmd.vector   = vi_reg;
        cmd.count    = n_eff;
        cmd.last_set = last_set;
    end

    gso_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .busy   (core_busy),
        .result (result)
    );

    assign busy           = core_busy;
    assign result_valid   = result.valid;
    assign basis_value    = result.value;
    assign last_of_vector = result.last_of_vector;
    assign last_of_set    = result.last_of_set;
    assign degenerate     = result.degenerate;

endmodule
`default_nettype wire

FILE: rtl/gso_checker.sv
`default_nettype none
`include "gram_schmidt_orthonormalizer_top_assert.svh"
module gso_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        result_valid,
    input wire logic [15:0] basis_value,
    input wire logic        last_of_vector,
    input wire logic        degenerate
);

    // Words of a vector come out while the block is still working on it.
    `GSO_AP_SAME(a_mid_word_busy, result_valid && !last_of_vector, busy)

    // A degenerate vector is all zero.
    `GSO_AP_SAME(a_degen_zero, result_valid && degenerate, basis_value == 16'h0000)

    // Read states lie between words, so strobes never come back to back.
    `GSO_AP_NEXT(a_no_back_to_back, result_valid, !result_valid)

    // No word comes out in the cycle right after a component is taken.
    `GSO_AP_NEXT(a_no_word_after_accept, start && !busy, !result_valid)

endmodule

bind gram_schmidt_orthonormalizer_top gso_checker u_gso_checker (.*);
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import gso_pkg::*;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [DATA_W-1:0] component_value = '0;
    logic                     result_valid;
    logic signed [DATA_W-1:0] basis_value;
    logic                     last_of_vector;
    logic                     last_of_set;
    logic                     degenerate;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_VECTORS;
    logic [CFG_W-1:0]         cfg_data = '0;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              lov;
        logic              los;
        logic              degen;
    } basis_word_t;

    // Orthonormal basis predictor with its own copy of the block state.
    class basis_scoreboard;
        logic signed [15:0] vec_buf [MAX_COMPONENTS];
        logic signed [15:0] basis [MAX_VECTORS * MAX_COMPONENTS];
        int unsigned        comp_idx;
        int unsigned        vec_idx;
        logic [CFG_W-1:0]   num_vectors;
        logic [CFG_W-1:0]   num_components;
        basis_word_t        pending [$];
        int                 mismatches;
        int                 words_checked;

        function new();
            comp_idx = 0;
            vec_idx = 0;
            num_vectors = 4'd8;
            num_components = 4'd8;
            mismatches = 0;
            words_checked = 0;
            foreach (basis[i]) basis[i] = '0;
            foreach (vec_buf[i]) vec_buf[i] = '0;
        endfunction

        function int clamp_count(logic [CFG_W-1:0] r, int lim);
            if (r == '0)
            begin
                return 1;
            end
            return (int'(r) > lim) ? lim : int'(r);
        endfunction

        function longint unsigned isqrt(longint unsigned num);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > num) b = b >> 2;
            while (b != 0)
            begin
                if (num >= res + b)
                begin
                    num = num - (res + b);
                    res = (res >> 1) + b;
                end
                else
                begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void note_component(logic signed [15:0] x);
            int n;
            int m;
            longint rem [MAX_COMPONENTS];
            longint unsigned mag [MAX_COMPONENTS];
            longint unsigned maxmag;
            longint unsigned sumsq;
            longint unsigned nrm;
            longint unsigned q;
            longint c;
            int s;
            bit last_set;
            bit degen;
            logic signed [15:0] val;
            basis_word_t w;
            n = clamp_count(num_components, MAX_COMPONENTS);
            m = clamp_count(num_vectors, MAX_VECTORS);
            vec_buf[comp_idx] = x;
            if (comp_idx + 1 < n)
            begin
                comp_idx++;
                return;
            end
            for (int k = 0; k < n; k++) rem[k] = longint'(vec_buf[k]) * 64'sd1073741824;
            for (int j = 0; j < vec_idx; j++)
            begin
                c = 0;
                for (int k = 0; k < n; k++)
                    c += longint'(vec_buf[k]) * longint'(basis[j * MAX_COMPONENTS + k]);
                for (int k = 0; k < n; k++)
                    rem[k] -= c * longint'(basis[j * MAX_COMPONENTS + k]);
            end
            maxmag = 0;
            for (int k = 0; k < n; k++)
            begin
                mag[k] = (rem[k] < 0) ? longint'(-rem[k]) : rem[k];
                if (mag[k] > maxmag) maxmag = mag[k];
            end
            s = 0;
            while ((maxmag >> s) >= (64'd1 << 28)) s++;
            sumsq = 0;
            for (int k = 0; k < n; k++)
            begin
                mag[k] = mag[k] >> s;
                sumsq += mag[k] * mag[k];
            end
            nrm = isqrt(sumsq);
            degen = (nrm == 0);
            last_set = (vec_idx + 1 >= m);
            for (int k = 0; k < n; k++)
            begin
                val = '0;
                if (!degen)
                begin
                    q = ((mag[k] << 15) + nrm / 2) / nrm;
                    if (rem[k] < 0)
                    begin
                        if (q > 32768) q = 32768;
                        val = 16'(-longint'(q));
                    end
                    else
                    begin
                        if (q > 32767) q = 32767;
                        val = 16'(q);
                    end
                end
                basis[vec_idx * MAX_COMPONENTS + k] = val;
                w.value = val;
                w.lov = (k + 1 == n);
                w.los = last_set;
                w.degen = degen;
                pending.push_back(w);
            end
            comp_idx = 0;
            vec_idx = last_set ? 0 : vec_idx + 1;
        endfunction

        task check_word(basis_word_t got);
            basis_word_t want;
            words_checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("word with no expectation waiting", got, got);
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value) report_mismatch("basis_value", got, want);
            if (got.lov !== want.lov) report_mismatch("last_of_vector", got, want);
            if (got.los !== want.los) report_mismatch("last_of_set", got, want);
            if (got.degen !== want.degen) report_mismatch("degenerate", got, want);
        endtask

        task report_mismatch(string what, basis_word_t got, basis_word_t want);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH %s: got %h/%b%b%b want %h/%b%b%b", what, got.value,
                         got.lov, got.los, got.degen, want.value, want.lov, want.los,
                         want.degen);
        endtask
    endclass

    basis_scoreboard sb;
    int  idle_pct = 32;
    int  quiet_cycles = 0;
    int  items_sent = 0;
    bit  timed_out = 0;
    localparam int WATCHDOG_LIMIT = 20000;

    gram_schmidt_orthonormalizer_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .component_value(component_value), .result_valid(result_valid),
        .basis_value(basis_value), .last_of_vector(last_of_vector),
        .last_of_set(last_of_set), .degenerate(degenerate),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                sb.check_word({basis_value, last_of_vector, last_of_set, degenerate});
            if ((start && !busy) || result_valid || cfg_we)
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
            begin
                timed_out = 1;
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("gram_schmidt_orthonormalizer_top regression: fail");
                $finish;
            end
        end
    end

    // Start stays high after the accepting edge until the next call or drain
    // decides, so it is assigned only once per edge.
    task automatic send_component(logic signed [15:0] x);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        component_value <= x;
        do @(posedge clk); while (busy);
        sb.note_component(x);
        items_sent++;
    endtask

    // Waits until every expected word has come and the block is idle, then a further margin.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0 || busy) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_VECTORS) sb.num_vectors = val;
        else sb.num_components = val;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_component();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Runs whole sets so that vectors and components stay aligned.
    task automatic run_sets(int sets, int nv, int nc);
        int ev;
        int ec;
        ev = sb.clamp_count(4'(nv), MAX_VECTORS);
        ec = sb.clamp_count(4'(nc), MAX_COMPONENTS);
        for (int s = 0; s < sets; s++)
            for (int v = 0; v < ev; v++)
                for (int c = 0; c < ec; c++)
                    send_component(rand_component());
    endtask

    initial
    begin
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, a zero vector, and a repeated (dependent) vector.
        write_reg(CFG_VECTORS, 4'd3);
        write_reg(CFG_COMPONENTS, 4'd2);
        send_component(16'sh7FFF); send_component(16'sh8000);
        send_component(16'sh0000); send_component(16'sh0000);
        send_component(16'sh7FFF); send_component(16'sh8000);
        send_component(16'sh0100); send_component(16'sh0000);
        send_component(16'sh0000); send_component(16'sh0100);
        send_component(16'shFFFF); send_component(16'sh0001);
        drain();
        // Register value zero acts as one; values above the limit saturate.
        write_reg(CFG_VECTORS, 4'd0);
        write_reg(CFG_COMPONENTS, 4'd15);
        run_sets(1, 0, 15);
        drain();
        write_reg(CFG_VECTORS, 4'd15);
        write_reg(CFG_COMPONENTS, 4'd0);
        idle_pct = 0;
        run_sets(1, 15, 0);
        drain();

        while (items_sent < 260)
        begin
            int nv;
            int nc;
            nv = $urandom_range(15);
            nc = $urandom_range(15);
            idle_pct = ($urandom_range(3) == 0) ? 0 : 32;
            write_reg(CFG_VECTORS, 4'(nv));
            write_reg(CFG_COMPONENTS, 4'(nc));
            run_sets($urandom_range(1, 2), nv, nc);
            drain();
        end

        $display("Sent %0d components and checked %0d basis words over", items_sent,
                 sb.words_checked);
        $display("register settings from zero to fifteen, including degenerate vectors.");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
        begin
            $display("gram_schmidt_orthonormalizer_top regression: pass");
        end
        else
        begin
            $display("gram_schmidt_orthonormalizer_top regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/gso_pkg.sv
rtl/gso_sqrt.sv
rtl/gso_div.sv
rtl/gso_core.sv
rtl/gram_schmidt_orthonormalizer_top.sv
rtl/gso_checker.sv
bench/tb_top.sv
